### sv/html_tag_stripper_unit_defines.svh
// Assertion macros used by the HTML tag stripper top level.
`ifndef HTML_TAG_STRIPPER_UNIT_DEFINES_SVH
`define HTML_TAG_STRIPPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define HTS_ASSERT(lbl, clk_i, rst_ni, prop) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
		else $error("html tag stripper assertion failed");
`define HTS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("html tag stripper assertion failed");
`else
`define HTS_ASSERT(lbl, clk_i, rst_ni, prop)
`define HTS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

### sv/hts_pkg.sv
// Types and constants shared by the HTML tag stripper modules.
`default_nettype none

package hts_pkg;

	localparam int MAX_TAG_LEN_DEF = 6;
	localparam int NUM_BLOCK_TAGS  = 9;
	localparam int TAG_MAX_CHARS   = 6;
	localparam int TAG_LEN_W       = 3;

	localparam logic [NUM_BLOCK_TAGS-1:0] BLOCK_TAG_MASK_RST = '1;

	localparam logic [7:0] CH_LT      = "<";
	localparam logic [7:0] CH_GT      = ">";
	localparam logic [7:0] CH_AMP     = "&";
	localparam logic [7:0] CH_SEMI    = ";";
	localparam logic [7:0] CH_SLASH   = "/";
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_Z = "Z";
	localparam logic [7:0] CH_HT      = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SP      = 8'd32;
	localparam logic [7:0] CH_NL      = 8'd10;
	localparam logic [7:0] CASE_OFS   = 8'd32;

	localparam logic [7:0] BLOCK_TAG_CHARS [NUM_BLOCK_TAGS][TAG_MAX_CHARS] = '{
		'{"p", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "i", "v", 8'h00, 8'h00, 8'h00},
		'{"b", "r", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"h", "1", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"h", "2", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "i", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "i", "t", "l", "e", 8'h00},
		'{"h", "e", "a", "d", "e", "r"},
		'{"f", "o", "o", "t", "e", "r"}
	};

	localparam logic [TAG_LEN_W-1:0] BLOCK_TAG_LENS [NUM_BLOCK_TAGS] = '{
		3'd1, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd6, 3'd6
	};

	typedef enum logic [2:0] {
		MODE_TEXT   = 3'b001,
		MODE_TAG    = 3'b010,
		MODE_ENTITY = 3'b100
	} hts_mode_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] ch;
	} hts_result_t;

endpackage

`default_nettype wire

### sv/hts_matcher.sv
// Parallel compare of the stored tag name against the enabled block tags.
`default_nettype none

module hts_matcher #(
	parameter int MAX_TAG_LEN = hts_pkg::MAX_TAG_LEN_DEF,
	localparam int LEN_W = $clog2(MAX_TAG_LEN + 1)
) (
	input  wire logic [MAX_TAG_LEN-1:0][7:0]           name_buf,
	input  wire logic [LEN_W-1:0]                      name_len,
	input  wire logic                                  name_overflow,
	input  wire logic [hts_pkg::NUM_BLOCK_TAGS-1:0]    mask,
	output logic                                       hit
);

	logic [hts_pkg::NUM_BLOCK_TAGS-1:0] tag_eq;

	always_comb begin
		for (int t = 0; t < hts_pkg::NUM_BLOCK_TAGS; t++) begin
			tag_eq[t] = mask[t] && (name_len == LEN_W'(hts_pkg::BLOCK_TAG_LENS[t]));
			for (int k = 0; k < hts_pkg::TAG_MAX_CHARS; k++) begin
				if ((k < int'(hts_pkg::BLOCK_TAG_LENS[t])) &&
				    (name_buf[k] != hts_pkg::BLOCK_TAG_CHARS[t][k])) begin
					tag_eq[t] = 1'b0;
				end
			end
		end
		hit = !name_overflow && (|tag_eq);
	end

endmodule

`default_nettype wire

### sv/hts_parser.sv
// Parse state, tag name store and per-byte result decode.
`default_nettype none

module hts_parser #(
	parameter int MAX_TAG_LEN = hts_pkg::MAX_TAG_LEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               step,
	input  wire logic [7:0]                         ch,
	input  wire logic [hts_pkg::NUM_BLOCK_TAGS-1:0] mask,
	output hts_pkg::hts_result_t                    res
);

	localparam int LEN_W = $clog2(MAX_TAG_LEN + 1);

	hts_pkg::hts_mode_t              mode_q, mode_d;
	logic [MAX_TAG_LEN-1:0][7:0]     name_q;
	logic [LEN_W-1:0]                len_q, len_d;
	logic                            done_q, done_d;
	logic                            ovf_q, ovf_d;
	logic                            wr_en;
	logic [7:0]                      lc_char;
	logic                            is_ws;
	logic                            hit;

	hts_matcher #(
		.MAX_TAG_LEN(MAX_TAG_LEN)
	) u_matcher (
		.name_buf     (name_q),
		.name_len     (len_q),
		.name_overflow(ovf_q),
		.mask         (mask),
		.hit          (hit)
	);

	assign is_ws = (ch == hts_pkg::CH_SP) || ((ch >= hts_pkg::CH_HT) && (ch <= hts_pkg::CH_CR));
	assign lc_char = ((ch >= hts_pkg::CH_UPPER_A) && (ch <= hts_pkg::CH_UPPER_Z)) ?
		ch + hts_pkg::CASE_OFS : ch;

	always_comb begin
		mode_d = mode_q;
		len_d  = len_q;
		done_d = done_q;
		ovf_d  = ovf_q;
		wr_en  = 1'b0;
		res    = '0;
		if (step) begin
			priority if (mode_q == hts_pkg::MODE_ENTITY) begin
				if (ch == hts_pkg::CH_SEMI) begin
					mode_d = hts_pkg::MODE_TEXT;
				end
			end else if (ch == hts_pkg::CH_LT) begin
				mode_d = hts_pkg::MODE_TAG;
				len_d  = '0;
				done_d = 1'b0;
				ovf_d  = 1'b0;
			end else if (ch == hts_pkg::CH_GT) begin
				mode_d   = hts_pkg::MODE_TEXT;
				res.emit = hit;
				res.ch   = hts_pkg::CH_NL;
			end else if (mode_q == hts_pkg::MODE_TAG) begin
				if (!((ch == hts_pkg::CH_SLASH) || done_q)) begin
					if (is_ws) begin
						done_d = 1'b1;
					end else if (len_q < LEN_W'(MAX_TAG_LEN)) begin
						wr_en = 1'b1;
						len_d = len_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
				end
			end else if (ch == hts_pkg::CH_AMP) begin
				mode_d   = hts_pkg::MODE_ENTITY;
				res.emit = 1'b1;
				res.ch   = hts_pkg::CH_SP;
			end else begin
				res.emit = 1'b1;
				res.ch   = ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hts_pkg::MODE_TEXT;
			name_q <= '0;
			len_q  <= '0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			len_q  <= len_d;
			done_q <= done_d;
			ovf_q  <= ovf_d;
			for (int i = 0; i < MAX_TAG_LEN; i++) begin
				if (wr_en && (len_q == LEN_W'(i))) begin
					name_q[i] <= lc_char;
				end
			end
		end
	end

endmodule

`default_nettype wire

### sv/html_tag_stripper_unit.sv
// Top level of the HTML tag stripper: input stage, parser, result register, mask register.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------
//  input    | in_valid / in_ready    | in_char   [7:0]
//  output   | out_valid / out_ready  | out_char  [7:0]
//  config   | cfg_we                 | cfg_wdata [8:0] (block tag mask)
//
//  One byte per cycle unless output stalls; bytes pass input stage, then result register.
//  The parser decodes the byte held in the input stage into the result register.
//  A byte that yields no text leaves the result register empty.
//  A stalled result holds the input stage; in_ready stays high while the output drains.
//  Reset clears parse state, tag name store and sets the mask to all ones.
`default_nettype none
`include "html_tag_stripper_unit_defines.svh"

module html_tag_stripper_unit #(
	parameter int MAX_TAG_LEN = hts_pkg::MAX_TAG_LEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         in_char,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              out_char,
	input  wire logic                               cfg_we,
	input  wire logic [hts_pkg::NUM_BLOCK_TAGS-1:0] cfg_wdata
);

	logic                               valid_s1;
	logic [7:0]                         char_s1;
	logic                               adv_s1;
	logic                               out_stall;
	logic                               out_valid_q;
	logic [7:0]                         out_char_q;
	logic [hts_pkg::NUM_BLOCK_TAGS-1:0] mask_q;
	hts_pkg::hts_result_t               res;

	assign out_stall = out_valid_q && !out_ready;
	assign adv_s1    = valid_s1 && !out_stall;
	assign in_ready  = !valid_s1 || adv_s1;

	hts_parser #(
		.MAX_TAG_LEN(MAX_TAG_LEN)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv_s1),
		.ch    (char_s1),
		.mask  (mask_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= hts_pkg::BLOCK_TAG_MASK_RST;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.emit) begin
			out_char_q <= res.ch;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;

	`HTS_ASSERT(a_ready_when_drained, clk, arst_n, (!out_valid || out_ready) |-> in_ready)
	`HTS_ASSERT_NEXT(a_stage_holds, clk, arst_n, valid_s1 && out_stall, valid_s1 && $stable(char_s1))
	`HTS_ASSERT(a_result_from_stage, clk, arst_n, $rose(out_valid) |-> $past(adv_s1))

endmodule

`default_nettype wire

### verif/html_tag_stripper_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HTML tag stripper: random markup in, predicted plain text out.
module html_tag_stripper_unit_tb;

	localparam int NAME_DEPTH  = hts_pkg::MAX_TAG_LEN_DEF;
	localparam int NTAGS       = hts_pkg::NUM_BLOCK_TAGS;
	localparam int CHUNK_BYTES = 85;
	localparam int HOLD_CYCLES = 120;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic [7:0]       in_char   = 8'h00;
	logic             out_ready = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [NTAGS-1:0] cfg_wdata = '0;
	logic             in_ready;
	logic             out_valid;
	logic [7:0]       out_char;

	string break_tags [NTAGS] = '{
		"p", "div", "br", "h1", "h2", "li", "title", "header", "footer"
	};

	logic [7:0] pending_bytes [$];
	logic [7:0] expected_text [$];
	int         tx_idle_pct  = 19;
	int         rx_idle_pct  = 46;
	int         bytes_taken  = 0;
	int         errors       = 0;
	int         hold_left    = 0;
	int         holds_done   = 0;
	int         next_hold_at = 400;

	hts_pkg::hts_mode_t parse_state   = hts_pkg::MODE_TEXT;
	logic [7:0]         name_bytes [NAME_DEPTH];
	int                 name_len      = 0;
	bit                 name_closed   = 1'b0;
	bit                 name_too_long = 1'b0;
	logic [NTAGS-1:0]   break_mask    = hts_pkg::BLOCK_TAG_MASK_RST;

	html_tag_stripper_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_char   (in_char),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit strip_byte(input logic [7:0] ch, output logic [7:0] txt);
		logic [7:0] c;
		bit         hit;
		bit         same;
		string      tag;
		c   = ch;
		txt = 8'h00;
		if (parse_state == hts_pkg::MODE_ENTITY) begin
			if (c == hts_pkg::CH_SEMI)
				parse_state = hts_pkg::MODE_TEXT;
			return 1'b0;
		end
		if (c == hts_pkg::CH_LT) begin
			parse_state   = hts_pkg::MODE_TAG;
			name_len      = 0;
			name_closed   = 1'b0;
			name_too_long = 1'b0;
			return 1'b0;
		end
		if (c == hts_pkg::CH_GT) begin
			parse_state = hts_pkg::MODE_TEXT;
			hit = 1'b0;
			for (int t = 0; t < NTAGS; t++) begin
				tag  = break_tags[t];
				same = !name_too_long && break_mask[t] && (tag.len() == name_len);
				for (int k = 0; k < name_len; k++)
					if (same && tag[k] != name_bytes[k])
						same = 1'b0;
				if (same)
					hit = 1'b1;
			end
			txt = hts_pkg::CH_NL;
			return hit;
		end
		if (parse_state == hts_pkg::MODE_TAG) begin
			if (c == hts_pkg::CH_SLASH || name_closed)
				return 1'b0;
			if (c == hts_pkg::CH_SP || (c >= hts_pkg::CH_HT && c <= hts_pkg::CH_CR)) begin
				name_closed = 1'b1;
				return 1'b0;
			end
			if (c >= hts_pkg::CH_UPPER_A && c <= hts_pkg::CH_UPPER_Z)
				c = c + hts_pkg::CASE_OFS;
			if (name_len < NAME_DEPTH) begin
				name_bytes[name_len] = c;
				name_len++;
			end else begin
				name_too_long = 1'b1;
			end
			return 1'b0;
		end
		if (c == hts_pkg::CH_AMP) begin
			parse_state = hts_pkg::MODE_ENTITY;
			txt = hts_pkg::CH_SP;
			return 1'b1;
		end
		txt = c;
		return 1'b1;
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(32, 126));
		while (ch == hts_pkg::CH_LT || ch == hts_pkg::CH_GT ||
			ch == hts_pkg::CH_AMP || ch == hts_pkg::CH_SLASH);
		return ch;
	endfunction

	task automatic push_str(input string s);
		for (int k = 0; k < s.len(); k++)
			pending_bytes.push_back(s[k]);
	endtask

	task automatic queue_markup(input int n);
		int         start;
		int         kind;
		string      tag;
		logic [7:0] ch;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < n) begin
			kind = $urandom_range(99);
			if (kind < 35) begin
				repeat ($urandom_range(1, 8))
					pending_bytes.push_back(plain_byte());
			end else if (kind < 70) begin
				pending_bytes.push_back(hts_pkg::CH_LT);
				if ($urandom_range(99) < 30)
					pending_bytes.push_back(hts_pkg::CH_SLASH);
				if ($urandom_range(99) < 60) begin
					tag = break_tags[$urandom_range(NTAGS - 1)];
					for (int k = 0; k < tag.len(); k++) begin
						ch = tag[k];
						if (ch >= "a" && ch <= "z" && $urandom_range(1) == 1)
							ch = ch - hts_pkg::CASE_OFS;
						pending_bytes.push_back(ch);
					end
				end else begin
					repeat ($urandom_range(1, 8))
						pending_bytes.push_back(plain_byte());
				end
				if ($urandom_range(99) < 40) begin
					if ($urandom_range(2) == 0)
						pending_bytes.push_back(hts_pkg::CH_SP);
					else
						pending_bytes.push_back(
							8'($urandom_range(hts_pkg::CH_HT, hts_pkg::CH_CR)));
					repeat ($urandom_range(6))
						pending_bytes.push_back(plain_byte());
				end
				if ($urandom_range(99) < 92)
					pending_bytes.push_back(hts_pkg::CH_GT);
			end else if (kind < 82) begin
				pending_bytes.push_back(hts_pkg::CH_AMP);
				repeat ($urandom_range(5)) begin
					if ($urandom_range(9) == 0)
						pending_bytes.push_back($urandom_range(1) ?
							hts_pkg::CH_LT : hts_pkg::CH_GT);
					else
						pending_bytes.push_back("a" + 8'($urandom_range(25)));
				end
				if ($urandom_range(99) < 95)
					pending_bytes.push_back(hts_pkg::CH_SEMI);
			end else if (kind < 88) begin
				pending_bytes.push_back(hts_pkg::CH_GT);
			end else begin
				repeat ($urandom_range(1, 4))
					pending_bytes.push_back(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic settle();
		while (pending_bytes.size() != 0 || in_valid || expected_text.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_mask(input logic [NTAGS-1:0] m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		break_mask = m;
	endtask

	always @(posedge clk) begin
		logic [7:0] txt;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				bytes_taken++;
				if (strip_byte(in_char, txt))
					expected_text.push_back(txt);
			end
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					in_valid <= 1'b1;
					in_char  <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (holds_done < 2 && bytes_taken >= next_hold_at
					&& pending_bytes.size() > 30) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				next_hold_at += 400;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_text.size() == 0) begin
				errors++;
				$display("%0t: out_char expected none, actual %02h", $time, out_char);
			end else begin
				want = expected_text.pop_front();
				if (out_char !== want) begin
					errors++;
					$display("%0t: out_char expected %02h, actual %02h",
						$time, want, out_char);
				end
			end
		end
	end

	initial begin
		logic [NTAGS-1:0] m;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		push_str("&<>;");
		push_str("</P");
		pending_bytes.push_back(hts_pkg::CH_HT);
		push_str("x>>");
		push_str("<footerZ>>");
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
			rx_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
			for (int chunk = 0; chunk < 4; chunk++) begin
				unique case (chunk)
					0: m = '0;
					1: m = NTAGS'($urandom_range(511));
					2: m = NTAGS'(1 << $urandom_range(NTAGS - 1));
					default: m = '1;
				endcase
				load_mask(m);
				queue_markup(CHUNK_BYTES);
				settle();
			end
		end

		if (errors == 0 && expected_text.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/hts_pkg.sv
sv/hts_matcher.sv
sv/hts_parser.sv
sv/html_tag_stripper_unit.sv
verif/html_tag_stripper_unit_tb.sv
